### hdl/dpg_pkg.sv
// Shared widths, register codes, the pipeline payload type and the power-of-ten table.
package dpg_pkg;

   localparam int MAX_DIGITS_DEF  = 18;
   localparam int DIGIT_COUNT_W   = 5;
   localparam int ORDINAL_W       = 30;
   localparam int VALUE_W         = 60;
   localparam int DIGIT_IDX_W     = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   // Register index, taken from byte address bit 2.
   localparam logic REG_DIGIT_COUNT = 1'b0;

   // Reciprocal of ten, exact for dividends below 2**32 with a shift of 35.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef struct packed {
      logic [ORDINAL_W-1:0]   x;
      logic [ORDINAL_W-1:0]   rev;
      logic [VALUE_W-1:0]     scaled;
      logic [DIGIT_IDX_W-1:0] n;
      logic                   skip;
      logic                   oor;
      logic                   last;
   } dpg_stage_type;

   function automatic logic [ORDINAL_W-1:0] pow10_f(input logic [DIGIT_IDX_W-1:0] e);
      logic [ORDINAL_W-1:0] p;
      case (e)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

### hdl/dpg_if.sv
// Valid/ready channel interfaces for ordinals in and palindromes out.
interface dpg_req_if;
   import dpg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ORDINAL_W-1:0] ordinal;
   modport source (output valid, output ordinal, input ready);
   modport sink   (input valid, input ordinal, output ready);
endinterface

interface dpg_rsp_if;
   import dpg_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] palindrome_value;
   logic               is_last;
   logic               status;
   modport source (output valid, output palindrome_value, output is_last, output status,
                   input ready);
   modport sink   (input valid, input palindrome_value, input is_last, input status,
                   output ready);
endinterface

### hdl/dpg_prep.sv
// First two pipeline stages: range check, first half, and scaling of the half.
module dpg_prep #(
   parameter int MAX_DIGITS = dpg_pkg::MAX_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              en_p1,
   input  logic                              en_p2,
   input  logic [dpg_pkg::DIGIT_COUNT_W-1:0] digit_count,
   input  logic [dpg_pkg::ORDINAL_W-1:0]     ordinal,
   output dpg_pkg::dpg_stage_type            stage_out
);
   import dpg_pkg::*;

   typedef struct packed {
      logic [ORDINAL_W-1:0]   half;
      logic [DIGIT_IDX_W-1:0] sc;
      logic [DIGIT_IDX_W-1:0] n;
      logic                   skip;
      logic                   oor;
      logic                   last;
   } dpg_p1_type;

   dpg_p1_type    p1_in, p1_ff;
   dpg_stage_type p2_in, p2_ff;

   logic [DIGIT_COUNT_W-1:0] len;
   logic [DIGIT_IDX_W-1:0]   h;
   logic [ORDINAL_W-1:0]     base;
   logic [ORDINAL_W-1:0]     count;

   always_comb begin
      if (digit_count > DIGIT_COUNT_W'(MAX_DIGITS)) begin
         len = DIGIT_COUNT_W'(MAX_DIGITS);
      end else if (digit_count == '0) begin
         len = DIGIT_COUNT_W'(1);
      end else begin
         len = digit_count;
      end
      h     = DIGIT_IDX_W'((len + DIGIT_COUNT_W'(1)) >> 1);
      base  = pow10_f(h - DIGIT_IDX_W'(1));
      count = (base << 3) + base;

      p1_in.half = base + ordinal;
      p1_in.sc   = DIGIT_IDX_W'(len - DIGIT_COUNT_W'(h));
      p1_in.n    = h;
      p1_in.skip = len[0];
      p1_in.oor  = (ordinal >= count);
      p1_in.last = (ordinal == count - ORDINAL_W'(1));
   end

   always_comb begin
      p2_in.x      = p1_ff.half;
      p2_in.rev    = '0;
      p2_in.scaled = VALUE_W'(p1_ff.half) * VALUE_W'(pow10_f(p1_ff.sc));
      p2_in.n      = p1_ff.n;
      p2_in.skip   = p1_ff.skip;
      p2_in.oor    = p1_ff.oor;
      p2_in.last   = p1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (en_p1) begin
         p1_ff <= p1_in;
      end
      if (en_p2) begin
         p2_ff <= p2_in;
      end
   end

   assign stage_out = p2_ff;

endmodule

### hdl/dpg_digit_stage.sv
// Mirror stage: peels the low decimal digit; unless skipped, it joins the reversed half.
module dpg_digit_stage (
   input  logic                   clock,
   input  logic                   en,
   input  dpg_pkg::dpg_stage_type stage_in,
   output dpg_pkg::dpg_stage_type stage_out
);
   import dpg_pkg::*;

   localparam int PROD_W = ORDINAL_W + 32;

   dpg_stage_type        st_in, st_ff;
   logic [PROD_W-1:0]    prod;
   logic [ORDINAL_W-1:0] quot;
   logic [ORDINAL_W-1:0] digit_wide;
   logic [ORDINAL_W-1:0] rev_times_ten;

   always_comb begin
      prod          = PROD_W'(stage_in.x) * PROD_W'(RECIP_TEN);
      quot          = ORDINAL_W'(prod[PROD_W-1:RECIP_SHIFT]);
      digit_wide    = stage_in.x - ((quot << 3) + (quot << 1));
      rev_times_ten = (stage_in.rev << 3) + (stage_in.rev << 1);

      st_in = stage_in;
      if (stage_in.n != '0) begin
         st_in.x = quot;
         st_in.n = stage_in.n - DIGIT_IDX_W'(1);
         if (stage_in.skip) begin
            // The middle digit of an odd length appears only once.
            st_in.skip = 1'b0;
         end else begin
            st_in.rev = rev_times_ten + ORDINAL_W'(digit_wide[3:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign stage_out = st_ff;

endmodule

### hdl/decimal_palindrome_generator.sv
// Top level of the decimal palindrome generator: CSR, pipeline control and result register.
// Throughput: one transfer per cycle while results are taken; every stage holds one multiplier or one wide add.
// Stalls: a stage moves when it is empty or its successor moves, so bubbles close up.
// Reset: synchronous and active high; it empties the pipeline and sets digit_count to 1.
module decimal_palindrome_generator #(
   parameter int MAX_DIGITS = dpg_pkg::MAX_DIGITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dpg_req_if.sink                        req_if,
   dpg_rsp_if.source                      rsp_if,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dpg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dpg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dpg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import dpg_pkg::*;

   // The mirror needs one digit stage per digit of the first half.
   localparam int NUM_DIGIT_STAGES = (MAX_DIGITS + 1) / 2;
   // Stage 0 checks the range and forms the half, stage 1 scales it, the digit stages
   // build the reversed half, and the last stage is the result register.
   localparam int NUM_STAGES = NUM_DIGIT_STAGES + 3;
   localparam int OUT_STAGE  = NUM_STAGES - 1;

   // Configuration register. Only writes at the digit_count index change it.
   logic [DIGIT_COUNT_W-1:0] digit_count_ff, digit_count_in;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      digit_count_in = digit_count_ff;
      if (csr_write && (csr_paddr[2] == REG_DIGIT_COUNT)) begin
         digit_count_in = csr_pwdata[DIGIT_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_W'(1);
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_DIGIT_COUNT) begin
         csr_prdata = CSR_DATA_W'(digit_count_ff);
      end
   end

   // Valid bits travel with the data. A stage advances when it is empty or when the
   // stage after it advances; the result register advances when it is empty or taken.
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[OUT_STAGE] = !vld_ff[OUT_STAGE] || rsp_if.ready;
      for (int i = OUT_STAGE - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_if.valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_if.ready = adv[0];

   // Datapath: the front stages, then the chain of digit stages.
   dpg_stage_type chain [NUM_DIGIT_STAGES+1];

   dpg_prep #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_prep (
      .clock       (clock),
      .en_p1       (adv[0]),
      .en_p2       (adv[1]),
      .digit_count (digit_count_ff),
      .ordinal     (req_if.ordinal),
      .stage_out   (chain[0])
   );

   for (genvar k = 0; k < NUM_DIGIT_STAGES; k++) begin : g_digit
      dpg_digit_stage u_digit (
         .clock     (clock),
         .en        (adv[k+2]),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   // Result register: the scaled half plus the reversed half, zero when out of range.
   dpg_stage_type      fin;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic               status_ff, status_in;

   always_comb begin
      fin       = chain[NUM_DIGIT_STAGES];
      value_in  = fin.oor ? '0 : fin.scaled + VALUE_W'(fin.rev);
      last_in   = fin.last && !fin.oor;
      status_in = fin.oor;
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         value_ff  <= value_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   assign rsp_if.valid            = vld_ff[OUT_STAGE];
   assign rsp_if.palindrome_value = value_ff;
   assign rsp_if.is_last          = last_ff;
   assign rsp_if.status           = status_ff;

   // A palindrome delivered as in range is never zero.
   a_ok_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.status) |-> (rsp_if.palindrome_value != '0))
      else $error("in-range result carries a zero value");

   // An out-of-range result is zero and never marked last.
   a_oor_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status) |-> (rsp_if.palindrome_value == '0 && !rsp_if.is_last))
      else $error("out-of-range result is not cleared");

   // A request transfer always lands in the first stage.
   a_req_lands : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> vld_ff[0])
      else $error("accepted request was dropped");

endmodule

### verif/decimal_palindrome_generator_tb.sv
// Self-checking testbench for the decimal palindrome generator: directed, random and stall tests.
module decimal_palindrome_generator_tb;
   import dpg_pkg::*;

   // Half clock period, reset length and the end-of-run guard, the last two in clock cycles.
   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 4;
   localparam int DIGIT_LIMIT    = MAX_DIGITS_DEF;
   // Scale of the final wait for stray results, in clock cycles.
   localparam int PIPE_LATENCY   = (DIGIT_LIMIT + 1) / 2 + 2;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int IDLE_PERCENT   = 7;
   localparam int HOLD_CYCLES    = 80;

   // Status codes carried by the result channel.
   localparam logic STATUS_OK           = 1'b0;
   localparam logic STATUS_OUT_OF_RANGE = 1'b1;

   // Byte address of the digit count register: index 0 in the word-aligned map.
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_DIGIT_COUNT = {REG_DIGIT_COUNT, 2'b00};

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               status;
   } palindrome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dpg_req_if req_bus ();
   dpg_rsp_if rsp_bus ();

   decimal_palindrome_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Expected palindromes in the order their ordinals were transferred.
   palindrome_type palindrome_q[$];

   // Shadow copy of the digit count register, used by the predictor.
   logic [DIGIT_COUNT_W-1:0] digit_count_cfg;

   // Knobs shared between the test tasks and the channel processes.
   logic send_idling;
   logic rsp_idling;
   logic rsp_hold;

   int error_count;
   int ordinals_sent;
   int palindromes_checked;
   int config_writes;

   always begin
      clock = 1'b1;
      #(CLOCK_HALF);
      clock = 1'b0;
      #(CLOCK_HALF);
   end

   // Number of palindromes with the given register setting. The register saturates at the
   // digit limit, and a setting of zero behaves as a single digit.
   function automatic logic [63:0] palindrome_count(input logic [DIGIT_COUNT_W-1:0] dc);
      int unsigned digits;
      logic [63:0] base;
      digits = dc;
      if (digits > DIGIT_LIMIT) digits = DIGIT_LIMIT;
      if (digits == 0) digits = 1;
      base = 64'd1;
      for (int i = 1; i < (digits + 1) / 2; i++) base = base * 64'd10;
      return base * 64'd9;
   endfunction

   // Predicts the result for one ordinal: the first half is the smallest half-length number
   // plus the ordinal, and the full value mirrors it, sharing the middle digit when the
   // digit count is odd.
   function automatic palindrome_type predict_palindrome(input logic [DIGIT_COUNT_W-1:0] dc,
                                                         input logic [ORDINAL_W-1:0] ord);
      palindrome_type r;
      int unsigned digits;
      logic [63:0] count;
      logic [63:0] half;
      logic [63:0] full;
      logic [63:0] rest;
      digits = dc;
      if (digits > DIGIT_LIMIT) digits = DIGIT_LIMIT;
      if (digits == 0) digits = 1;
      count = palindrome_count(dc);
      r = '0;
      if ({34'd0, ord} >= count) begin
         r.status = STATUS_OUT_OF_RANGE;
         return r;
      end
      half = count / 64'd9 + {34'd0, ord};
      full = half;
      rest = digits[0] ? half / 64'd10 : half;
      while (rest != 0) begin
         full = full * 64'd10 + rest % 64'd10;
         rest = rest / 64'd10;
      end
      r.value  = full[VALUE_W-1:0];
      r.last   = ({34'd0, ord} == count - 64'd1);
      r.status = STATUS_OK;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Offers one ordinal and waits for its transfer. With idling enabled the valid line is
   // now and then dropped before the ordinal is offered. Valid is left high on return so
   // that back to back ordinals stream without a bubble; end_burst lowers it.
   task automatic send_ordinal(input logic [ORDINAL_W-1:0] ord);
      if (send_idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.ordinal <= ord;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      palindrome_q.insert(palindrome_q.size(), predict_palindrome(digit_count_cfg, ord));
      ordinals_sent++;
   endtask

   task automatic end_burst();
      req_bus.valid <= 1'b0;
   endtask

   // Waits until every expected palindrome has arrived. The block gives one result per
   // ordinal, so an empty queue means the pipeline holds nothing more.
   task automatic drain_results();
      end_burst();
      while (palindrome_q.size() != 0) @(posedge clock);
   endtask

   // APB write: a setup cycle, then an access cycle that completes while pready is high.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_ADDR_DIGIT_COUNT) digit_count_cfg = data[DIGIT_COUNT_W-1:0];
      config_writes++;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_digit_count_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_read(CSR_ADDR_DIGIT_COUNT, rd);
      if (rd !== {{(CSR_DATA_W-DIGIT_COUNT_W){1'b0}}, digit_count_cfg})
         report_mismatch($sformatf("digit_count reads %0d, expected %0d", rd, digit_count_cfg));
   endtask

   // Changes the digit count only once the block is idle, then reads it back.
   task automatic set_digit_count(input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_write(CSR_ADDR_DIGIT_COUNT, data);
      check_digit_count_readback();
   endtask

   // Picks an ordinal for the current setting: mostly in range, some right at the edges of
   // the range, and some from the whole 30-bit field so that every bit toggles.
   function automatic logic [ORDINAL_W-1:0] pick_ordinal();
      logic [63:0] count;
      int unsigned sel;
      count = palindrome_count(digit_count_cfg);
      sel = $urandom_range(99);
      if (sel < 80) return ORDINAL_W'($urandom_range(0, int'(count) - 1));
      if (sel < 84) return ORDINAL_W'(count - 64'd1);
      if (sel < 86) return '0;
      if (sel < 90) return ORDINAL_W'(count);
      return ORDINAL_W'($urandom());
   endfunction

   // The register must come out of reset at one digit: ordinals 0..8 give 1..9 and 9 is
   // the first out-of-range ordinal.
   task automatic test_reset_default();
      digit_count_cfg = DIGIT_COUNT_W'(1);
      check_digit_count_readback();
      send_ordinal('0);
      send_ordinal(ORDINAL_W'(8));
      send_ordinal(ORDINAL_W'(9));
      drain_results();
   endtask

   // Field extremes, the saturated and zero digit counts, both parities of the digit count,
   // the last palindrome of most settings and ordinals past the end.
   task automatic test_directed_extremes();
      set_digit_count(32'd18);
      send_ordinal('0);
      send_ordinal(ORDINAL_W'(899999999));
      send_ordinal(ORDINAL_W'(900000000));
      send_ordinal('1);
      send_ordinal(ORDINAL_W'(30'h2AAA_AAAA));
      set_digit_count(32'd17);
      send_ordinal('0);
      send_ordinal(ORDINAL_W'(899999999));
      send_ordinal(ORDINAL_W'(30'h1555_5555));
      set_digit_count(32'd2);
      send_ordinal('0);
      send_ordinal(ORDINAL_W'(8));
      send_ordinal(ORDINAL_W'(9));
      // A zero digit count behaves as one digit.
      set_digit_count(32'd0);
      send_ordinal(ORDINAL_W'(4));
      send_ordinal(ORDINAL_W'(9));
      // Settings above the digit limit saturate to it.
      set_digit_count(32'd31);
      send_ordinal(ORDINAL_W'(123456789));
      send_ordinal(ORDINAL_W'(899999999));
      set_digit_count(32'd19);
      send_ordinal(ORDINAL_W'(900000000));
      set_digit_count(32'd3);
      send_ordinal(ORDINAL_W'(89));
      send_ordinal(ORDINAL_W'(90));
      drain_results();
   endtask

   // Random ordinals over a series of digit counts. One phase runs with no idling on
   // either side, so that transfers stream back to back through the pipeline.
   task automatic test_random_sweep();
      logic [DIGIT_COUNT_W-1:0] counts [11];
      logic [CSR_DATA_W-1:0]    data;
      counts = '{5'd1, 5'd18, 5'd0, 5'd31, 5'd2, 5'd9, 5'd10, 5'd17, 5'd20, 5'd5, 5'd12};
      for (int phase = 0; phase < 11; phase++) begin
         // Junk in the unused upper bits of the write must not matter.
         data = {27'($urandom()), 5'd0} | {27'd0, counts[phase]};
         if (phase == 10) data[DIGIT_COUNT_W-1:0] = DIGIT_COUNT_W'($urandom_range(0, 31));
         set_digit_count(data);
         send_idling = (phase != 5);
         rsp_idling  = (phase != 5);
         for (int k = 0; k < 33; k++) send_ordinal(pick_ordinal());
         drain_results();
      end
      send_idling = 1'b1;
      rsp_idling  = 1'b1;
   endtask

   // The receiver holds off for a long stretch while ordinals keep coming, so the pipeline
   // fills and the input stalls; the hold is timed by its own process.
   task automatic test_output_stall();
      set_digit_count(32'd14);
      fork
         begin
            for (int k = 0; k < 40; k++) send_ordinal(pick_ordinal());
            end_burst();
         end
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join
      drain_results();
   endtask

   // The sender stops until every result has come back, then resumes on the same setting.
   task automatic test_sender_pause();
      set_digit_count(32'd7);
      for (int k = 0; k < 20; k++) send_ordinal(pick_ordinal());
      drain_results();
      for (int k = 0; k < 20; k++) send_ordinal(pick_ordinal());
      drain_results();
   endtask

   // Result receiver: random short stalls, a forced hold when asked, none in idle-free phases.
   always @(posedge clock) begin
      if (rsp_hold)
         rsp_bus.ready <= 1'b0;
      else if (rsp_idling && $urandom_range(99) < IDLE_PERCENT)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= 1'b1;
   end

   // Compares each result transfer with the oldest pending expectation, field by field.
   always @(posedge clock) begin : check_results
      palindrome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (palindrome_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d", rsp_bus.palindrome_value));
         end else begin
            want = palindrome_q.pop_front();
            if (rsp_bus.palindrome_value !== want.value)
               report_mismatch($sformatf("palindrome_value %0d, expected %0d",
                                         rsp_bus.palindrome_value, want.value));
            if (rsp_bus.is_last !== want.last)
               report_mismatch($sformatf("is_last %b, expected %b (value %0d)",
                                         rsp_bus.is_last, want.last, want.value));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %b, expected %b (value %0d)",
                                         rsp_bus.status, want.status, want.value));
            palindromes_checked++;
         end
      end
   end

   initial begin
      #(2 * CLOCK_HALF * TIMEOUT_CYCLES);
      $display("Timeout with %0d results still pending", palindrome_q.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      error_count         = 0;
      ordinals_sent       = 0;
      palindromes_checked = 0;
      config_writes       = 0;
      digit_count_cfg     = DIGIT_COUNT_W'(1);
      send_idling         = 1'b1;
      rsp_idling          = 1'b1;
      reset           <= 1'b1;
      rsp_hold        <= 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.ordinal <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_directed_extremes();
      test_random_sweep();
      test_output_stall();
      test_sender_pause();

      // Everything has been accepted; give the pipeline time to show any stray result,
      // then flag expectations that never arrived.
      end_burst();
      for (int c = 0; c < 4 * PIPE_LATENCY && palindrome_q.size() != 0; c++) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (palindrome_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", palindrome_q.size()));

      $display("Sent %0d ordinals and checked %0d palindromes over %0d digit count writes.",
               ordinals_sent, palindromes_checked, config_writes);
      $display("Covered zero and saturated counts, range edges, a long output hold and pauses.");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
